/* design/psc_pkg.sv */
// ---------------------------------------------------------------------------
// psc_pkg: shared types and constants of the plane side classifier
// Field widths, primitive and side codes, register indexes and the
// bundles that travel between the pipeline stages.
// ---------------------------------------------------------------------------
package psc_pkg;

   // operand and intermediate widths
   localparam int COORD_W = 32;
   localparam int TOL_W   = 31;
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int PAIR_W  = PROD_W + 1;
   localparam int SUM_W   = PROD_W + 2;
   localparam int FLOOR_W = SUM_W - FRAC_W;
   localparam int DIST_W  = FLOOR_W + 1;
   localparam int CORNERS = 8;
   localparam int PAIRS   = 4;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [TOL_W-1:0]   tol_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [PAIR_W-1:0]  pair_type;
   typedef logic signed [FLOOR_W-1:0] floor_type;
   typedef logic signed [DIST_W-1:0]  dist_type;

   // primitive kinds
   typedef enum logic [1:0] {
      CMD_POINT  = 2'd0,
      CMD_BOX    = 2'd1,
      CMD_SPHERE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // classification result
   typedef enum logic [1:0] {
      SIDE_FRONT = 2'd0,
      SIDE_BACK  = 2'd1,
      SIDE_CROSS = 2'd2
   } side_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_PLANE_A  = 3'd0,
      REG_PLANE_B  = 3'd1,
      REG_PLANE_C  = 3'd2,
      REG_OFFSET   = 3'd3,
      REG_EPSILON  = 3'd4
   } reg_type;

   // reset values of the plane and tolerance
   localparam coord_type PLANE_A_RST = 32'sh0000_0000;
   localparam coord_type PLANE_B_RST = 32'sh0000_0000;
   localparam coord_type PLANE_C_RST = 32'sh0001_0000;
   localparam coord_type OFFSET_RST  = 32'sh0000_0000;
   localparam tol_type   EPSILON_RST = 31'd1;

   // item attributes carried alongside the arithmetic
   typedef struct packed {
      cmd_type cmd;
      tol_type radius;
   } tag_type;

   // the six distinct products of normal and box coordinates
   typedef struct packed {
      prod_type ax0;
      prod_type ax1;
      prod_type by0;
      prod_type by1;
      prod_type cz0;
      prod_type cz1;
   } prod_set_type;

   typedef dist_type [CORNERS-1:0] dist_set_type;

   // per corner comparison results
   typedef struct packed {
      logic [CORNERS-1:0] near;
      logic [CORNERS-1:0] pos;
      logic [CORNERS-1:0] neg;
      logic               rad_hit;
   } flag_set_type;

endpackage

/* design/psc_mul.sv */
// ---------------------------------------------------------------------------
// psc_mul: product stage
// Forms the six signed 32x32 products of the plane normal with the min
// and max coordinates of the item, one register stage.
// ---------------------------------------------------------------------------
module psc_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  psc_pkg::tag_type      in_tag,
   input  psc_pkg::coord_type    x0,
   input  psc_pkg::coord_type    y0,
   input  psc_pkg::coord_type    z0,
   input  psc_pkg::coord_type    x1,
   input  psc_pkg::coord_type    y1,
   input  psc_pkg::coord_type    z1,
   input  psc_pkg::coord_type    plane_a,
   input  psc_pkg::coord_type    plane_b,
   input  psc_pkg::coord_type    plane_c,
   output logic                  out_valid,
   input  logic                  out_ready,
   output psc_pkg::prod_set_type out_prod,
   output psc_pkg::tag_type      out_tag
);

   logic                  valid_ff;
   logic                  valid_in;
   logic                  en;
   psc_pkg::prod_set_type prod_ff;
   psc_pkg::prod_set_type prod_in;
   psc_pkg::tag_type      tag_ff;

   // stage moves when empty or when the next stage takes its contents
   assign en       = !valid_ff || out_ready;
   assign in_ready = en;
   assign valid_in = in_valid;

   // products
   always_comb begin
      prod_in.ax0 = plane_a * x0;
      prod_in.ax1 = plane_a * x1;
      prod_in.by0 = plane_b * y0;
      prod_in.by1 = plane_b * y1;
      prod_in.cz0 = plane_c * z0;
      prod_in.cz1 = plane_c * z1;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         prod_ff <= prod_in;
         tag_ff  <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;
   assign out_tag   = tag_ff;

endmodule

/* design/psc_sum.sv */
// ---------------------------------------------------------------------------
// psc_sum: distance summation stages
// Three stages: x/y pair sums, corner sums floored to Q34.16, and the
// plane offset added, giving the signed distance of all eight corners.
// ---------------------------------------------------------------------------
module psc_sum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  psc_pkg::prod_set_type in_prod,
   input  psc_pkg::tag_type      in_tag,
   input  psc_pkg::coord_type    plane_offset,
   output logic                  out_valid,
   input  logic                  out_ready,
   output psc_pkg::dist_set_type out_dist,
   output psc_pkg::tag_type      out_tag
);

   // stage enables and valid bits
   logic pair_en;
   logic flr_en;
   logic dist_en;
   logic pair_valid_ff;
   logic flr_valid_ff;
   logic dist_valid_ff;

   // stage payloads
   psc_pkg::pair_type  pair_ff [psc_pkg::PAIRS];
   psc_pkg::pair_type  pair_in [psc_pkg::PAIRS];
   psc_pkg::prod_type  cz0_ff;
   psc_pkg::prod_type  cz1_ff;
   psc_pkg::tag_type   pair_tag_ff;
   psc_pkg::floor_type flr_ff  [psc_pkg::CORNERS];
   psc_pkg::floor_type flr_in  [psc_pkg::CORNERS];
   psc_pkg::tag_type   flr_tag_ff;
   psc_pkg::dist_set_type dist_ff;
   psc_pkg::dist_set_type dist_in;
   psc_pkg::tag_type   dist_tag_ff;

   // bubbles collapse: a stage moves when empty or when the next one moves
   assign dist_en  = !dist_valid_ff || out_ready;
   assign flr_en   = !flr_valid_ff  || dist_en;
   assign pair_en  = !pair_valid_ff || flr_en;
   assign in_ready = pair_en;

   // a*x + b*y for the four x/y corner combinations
   always_comb begin
      psc_pkg::prod_type px;
      psc_pkg::prod_type py;
      for (int j = 0; j < psc_pkg::PAIRS; j++) begin
         px = ((j & 1) != 0) ? in_prod.ax1 : in_prod.ax0;
         py = ((j & 2) != 0) ? in_prod.by1 : in_prod.by0;
         pair_in[j] = {px[psc_pkg::PROD_W-1], px} + {py[psc_pkg::PROD_W-1], py};
      end
   end

   // full corner sum, floored by dropping the fraction bits
   always_comb begin
      psc_pkg::pair_type             pr;
      psc_pkg::prod_type             pz;
      logic signed [psc_pkg::SUM_W-1:0] total;
      for (int i = 0; i < psc_pkg::CORNERS; i++) begin
         pr = pair_ff[i % psc_pkg::PAIRS];
         pz = ((i & 4) != 0) ? cz1_ff : cz0_ff;
         total = {pr[psc_pkg::PAIR_W-1], pr} + {{2{pz[psc_pkg::PROD_W-1]}}, pz};
         flr_in[i] = total[psc_pkg::SUM_W-1:psc_pkg::FRAC_W];
      end
   end

   // plane offset added at full width
   always_comb begin
      for (int i = 0; i < psc_pkg::CORNERS; i++) begin
         dist_in[i] = {flr_ff[i][psc_pkg::FLOOR_W-1], flr_ff[i]}
                    + {{(psc_pkg::DIST_W-psc_pkg::COORD_W){plane_offset[psc_pkg::COORD_W-1]}},
                       plane_offset};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         flr_valid_ff  <= 1'b0;
         dist_valid_ff <= 1'b0;
      end else begin
         if (pair_en) begin
            pair_valid_ff <= in_valid;
         end
         if (flr_en) begin
            flr_valid_ff <= pair_valid_ff;
         end
         if (dist_en) begin
            dist_valid_ff <= flr_valid_ff;
         end
      end
   end

   // payloads
   always_ff @(posedge clock) begin
      if (pair_en && in_valid) begin
         pair_ff     <= pair_in;
         cz0_ff      <= in_prod.cz0;
         cz1_ff      <= in_prod.cz1;
         pair_tag_ff <= in_tag;
      end
      if (flr_en && pair_valid_ff) begin
         flr_ff     <= flr_in;
         flr_tag_ff <= pair_tag_ff;
      end
      if (dist_en && flr_valid_ff) begin
         dist_ff     <= dist_in;
         dist_tag_ff <= flr_tag_ff;
      end
   end

   assign out_valid = dist_valid_ff;
   assign out_dist  = dist_ff;
   assign out_tag   = dist_tag_ff;

endmodule

/* design/psc_decide.sv */
// ---------------------------------------------------------------------------
// psc_decide: comparison and decision stages
// Compares corner distances against tolerance, radius and zero, then
// folds the flags into the side code held in the output register.
// ---------------------------------------------------------------------------
module psc_decide (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  psc_pkg::dist_set_type in_dist,
   input  psc_pkg::tag_type      in_tag,
   input  psc_pkg::tol_type      epsilon,
   output logic                  out_valid,
   input  logic                  out_ready,
   output psc_pkg::side_type     out_side
);

   logic                  cmp_en;
   logic                  side_en;
   logic                  cmp_valid_ff;
   logic                  side_valid_ff;
   psc_pkg::flag_set_type flag_ff;
   psc_pkg::flag_set_type flag_in;
   psc_pkg::cmd_type      cmd_ff;
   psc_pkg::side_type     side_ff;
   psc_pkg::side_type     side_in;
   psc_pkg::dist_type     eps_pos;
   psc_pkg::dist_type     eps_neg;
   psc_pkg::dist_type     rad_pos;
   psc_pkg::dist_type     rad_neg;
   psc_pkg::dist_type     d0;

   assign side_en  = !side_valid_ff || out_ready;
   assign cmp_en   = !cmp_valid_ff  || side_en;
   assign in_ready = cmp_en;

   // tolerance and radius as signed distance-wide bounds
   assign eps_pos = {{(psc_pkg::DIST_W-psc_pkg::TOL_W){1'b0}}, epsilon};
   assign eps_neg = -eps_pos;
   assign rad_pos = {{(psc_pkg::DIST_W-psc_pkg::TOL_W){1'b0}}, in_tag.radius};
   assign rad_neg = -rad_pos;
   assign d0      = $signed(in_dist[0]);

   // per corner flags
   always_comb begin
      psc_pkg::dist_type d;
      for (int i = 0; i < psc_pkg::CORNERS; i++) begin
         d = $signed(in_dist[i]);
         flag_in.near[i] = (d < eps_pos) && (d > eps_neg);
         flag_in.pos[i]  = (d > 0);
         flag_in.neg[i]  = (d < 0);
      end
      flag_in.rad_hit = (d0 <= rad_pos) && (d0 >= rad_neg);
   end

   // fold flags into the side code
   always_comb begin
      logic sign_clash;
      sign_clash = flag_ff.pos[0] ? (|flag_ff.neg[psc_pkg::CORNERS-1:1])
                                  : (|flag_ff.pos[psc_pkg::CORNERS-1:1]);
      case (cmd_ff)
         psc_pkg::CMD_POINT: begin
            if (flag_ff.near[0]) begin
               side_in = psc_pkg::SIDE_CROSS;
            end else begin
               side_in = flag_ff.pos[0] ? psc_pkg::SIDE_FRONT : psc_pkg::SIDE_BACK;
            end
         end
         psc_pkg::CMD_BOX: begin
            if ((|flag_ff.near) || sign_clash) begin
               side_in = psc_pkg::SIDE_CROSS;
            end else begin
               side_in = flag_ff.pos[0] ? psc_pkg::SIDE_FRONT : psc_pkg::SIDE_BACK;
            end
         end
         psc_pkg::CMD_SPHERE: begin
            if (flag_ff.rad_hit) begin
               side_in = psc_pkg::SIDE_CROSS;
            end else begin
               side_in = flag_ff.pos[0] ? psc_pkg::SIDE_FRONT : psc_pkg::SIDE_BACK;
            end
         end
         default: begin
            // unused kind: conservative answer
            side_in = psc_pkg::SIDE_CROSS;
         end
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff  <= 1'b0;
         side_valid_ff <= 1'b0;
      end else begin
         if (cmp_en) begin
            cmp_valid_ff <= in_valid;
         end
         if (side_en) begin
            side_valid_ff <= cmp_valid_ff;
         end
      end
   end

   // payloads
   always_ff @(posedge clock) begin
      if (cmp_en && in_valid) begin
         flag_ff <= flag_in;
         cmd_ff  <= in_tag.cmd;
      end
      if (side_en && cmp_valid_ff) begin
         side_ff <= side_in;
      end
   end

   assign out_valid = side_valid_ff;
   assign out_side  = side_ff;

endmodule

/* design/plane_side_classifier.sv */
// ---------------------------------------------------------------------------
// plane_side_classifier: point, box and sphere side test against a plane
// Top level: configuration registers and the six-stage classification pipe.
// ---------------------------------------------------------------------------
// Usage
//   The plane (a, b, c, d) and the tolerance are written through the csr_
//   port while no item is in flight; writes take effect at once.
//   An item (kind, min or centre corner, max corner, radius) is a transfer
//   on the req_ channel; its side code comes back as a transfer on rsp_.
//   Results leave in the order the items came in, one result per item.
// Stages and throughput
//   Between a req_ transfer and its rsp_ transfer the item passes the
//   product, pair sum, corner sum, offset add, compare and decision
//   stages, each registered.
//   All eight box corners are worked in parallel lanes, so one item is
//   taken every cycle for any mix of kinds unless the pipe is stalled.
// Reset
//   Clears every stage valid bit and loads the default plane z = 0 with
//   tolerance one LSB; there is no clearing pass.
// Stalls
//   When rsp_ready is low the output holds; earlier stages keep filling any
//   empty slots, and req_ready falls only once every stage holds an item.
// ---------------------------------------------------------------------------
module plane_side_classifier (
   input  logic        clock,
   input  logic        reset,
   // item channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_x0,
   input  logic [31:0] req_y0,
   input  logic [31:0] req_z0,
   input  logic [31:0] req_x1,
   input  logic [31:0] req_y1,
   input  logic [31:0] req_z1,
   input  logic [30:0] req_radius,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_side,
   // configuration port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   psc_pkg::coord_type    plane_a_ff;
   psc_pkg::coord_type    plane_b_ff;
   psc_pkg::coord_type    plane_c_ff;
   psc_pkg::coord_type    offset_ff;
   psc_pkg::tol_type      epsilon_ff;
   psc_pkg::tag_type      req_tag;
   logic                  mul_valid;
   logic                  mul_ready;
   psc_pkg::prod_set_type mul_prod;
   psc_pkg::tag_type      mul_tag;
   logic                  sum_valid;
   logic                  sum_ready;
   psc_pkg::dist_set_type sum_dist;
   psc_pkg::tag_type      sum_tag;
   psc_pkg::side_type     side;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_a_ff <= psc_pkg::PLANE_A_RST;
         plane_b_ff <= psc_pkg::PLANE_B_RST;
         plane_c_ff <= psc_pkg::PLANE_C_RST;
         offset_ff  <= psc_pkg::OFFSET_RST;
         epsilon_ff <= psc_pkg::EPSILON_RST;
      end else if (csr_we) begin
         case (psc_pkg::reg_type'(csr_index))
            psc_pkg::REG_PLANE_A: plane_a_ff <= csr_wdata;
            psc_pkg::REG_PLANE_B: plane_b_ff <= csr_wdata;
            psc_pkg::REG_PLANE_C: plane_c_ff <= csr_wdata;
            psc_pkg::REG_OFFSET:  offset_ff  <= csr_wdata;
            psc_pkg::REG_EPSILON: epsilon_ff <= csr_wdata[psc_pkg::TOL_W-1:0];
            default: begin
               // unmapped index: write ignored
            end
         endcase
      end
   end

   // item attributes that ride along the pipe
   assign req_tag.cmd    = psc_pkg::cmd_type'(req_cmd);
   assign req_tag.radius = req_radius;

   // products
   psc_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_tag    (req_tag),
      .x0        (req_x0),
      .y0        (req_y0),
      .z0        (req_z0),
      .x1        (req_x1),
      .y1        (req_y1),
      .z1        (req_z1),
      .plane_a   (plane_a_ff),
      .plane_b   (plane_b_ff),
      .plane_c   (plane_c_ff),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_prod  (mul_prod),
      .out_tag   (mul_tag)
   );

   // corner distances
   psc_sum u_sum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mul_valid),
      .in_ready     (mul_ready),
      .in_prod      (mul_prod),
      .in_tag       (mul_tag),
      .plane_offset (offset_ff),
      .out_valid    (sum_valid),
      .out_ready    (sum_ready),
      .out_dist     (sum_dist),
      .out_tag      (sum_tag)
   );

   // comparisons and side decision
   psc_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_dist   (sum_dist),
      .in_tag    (sum_tag),
      .epsilon   (epsilon_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_side  (side)
   );

   assign rsp_side = side;

`ifndef SYNTHESIS
   // an empty output register means every stage can move, so an item is taken
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("req_ready low while the output register is empty");

   // reset empties the pipe
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result presented straight after reset");

   // a stage full of bubbles never blocks intake behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
                    !mul_valid |-> req_ready)
      else $error("intake stalled with an empty product stage");
`endif

endmodule
